// ===== design/wsdf_pkg.sv =====
// Package for the WebSocket frame deframer: phase codes, opcodes, status codes
// and header field constants.
// No dependencies; used by websocket_frame_deframer.
package wsdf_pkg;

    localparam int LEN_BITS_DEF = 63;

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;

    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_CLOSED = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    localparam logic [7:0] OPCODE_MASK = 8'h0f;
    localparam logic [7:0] MASK_BIT    = 8'h80;
    localparam logic [7:0] LEN7_MASK   = 8'h7f;
    localparam logic [6:0] LEN7_EXT16  = 7'd126;
    localparam logic [6:0] LEN7_EXT64  = 7'd127;

    localparam logic [2:0] EXT16_BYTES = 3'd2;
    // Eight extension bytes wrap to zero in the 3-bit counter; the first
    // decrement brings it to seven.
    localparam logic [2:0] EXT64_BYTES = 3'd0;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

endpackage

// ===== design/websocket_frame_deframer.sv =====
// Path: an accepted input word is held in the input register, and its result is loaded
// into the result register when the word advances (the result register is free or drained).
// Throughput: one word per cycle, sustained while m_tready stays high; the
// header, extended length and key are parsed in the same single pass.
// Reset (rst_n low, asynchronous) returns the parser to header byte zero and
// clears the stopped flag and both valid registers.
module websocket_frame_deframer #(
    parameter int LEN_BITS = wsdf_pkg::LEN_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // frame_end
    output logic [6:0] m_tuser    // [3:0] frame_opcode, [4] byte_valid, [6:5] status
);

    logic                in_valid_reg, in_valid_next;
    logic [7:0]          in_byte_reg;

    logic [2:0]          phase_reg, phase_next;
    logic [3:0]          cur_opcode_reg, cur_opcode_next;
    logic [LEN_BITS-1:0] remaining_len_reg, remaining_len_next;
    logic [2:0]          ext_byte_count_reg, ext_byte_count_next;
    logic [31:0]         mask_key_reg, mask_key_next;
    logic [1:0]          mask_pos_reg, mask_pos_next;
    logic                stopped_reg, stopped_next;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic [3:0]          out_opcode_reg, out_opcode_next;
    logic                out_bvalid_reg, out_bvalid_next;
    logic                out_end_reg, out_end_next;
    logic [1:0]          out_status_reg, out_status_next;

    logic                advance;
    logic                s_accept;
    logic                is_data;
    logic                emit;
    logic [7:0]          key_byte;
    logic [LEN_BITS-1:0] len_dec;
    logic [2:0]          ext_dec;
    logic [2:0]          key_inc;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign is_data  = (cur_opcode_reg == wsdf_pkg::OP_TEXT) ||
                      (cur_opcode_reg == wsdf_pkg::OP_BINARY);
    // Key byte zero sits in bits 31..24, so position p selects byte 3 - p.
    assign key_byte = mask_key_reg[{~mask_pos_reg, 3'b000} +: 8];
    assign len_dec  = remaining_len_reg - LEN_BITS'(1);
    assign ext_dec  = ext_byte_count_reg - 3'd1;
    assign key_inc  = ext_byte_count_reg + 3'd1;

    always_comb
    begin
        phase_next          = phase_reg;
        cur_opcode_next     = cur_opcode_reg;
        remaining_len_next  = remaining_len_reg;
        ext_byte_count_next = ext_byte_count_reg;
        mask_key_next       = mask_key_reg;
        mask_pos_next       = mask_pos_reg;
        stopped_next        = stopped_reg;
        emit                = 1'b0;
        out_byte_next       = 8'd0;
        out_bvalid_next     = 1'b0;
        out_end_next        = 1'b0;
        out_status_next     = wsdf_pkg::ST_OK;
        out_opcode_next     = cur_opcode_reg;

        if (advance && !stopped_reg)
        begin
            case (phase_reg)
                wsdf_pkg::PH_HDR1:
                begin
                    if ((in_byte_reg & wsdf_pkg::MASK_BIT) == 8'd0)
                    begin
                        stopped_next    = 1'b1;
                        phase_next      = wsdf_pkg::PH_HDR0;
                        emit            = 1'b1;
                        out_end_next    = 1'b1;
                        out_status_next = wsdf_pkg::ST_ERROR;
                    end
                    else
                    begin
                        remaining_len_next  = '0;
                        ext_byte_count_next = 3'd0;
                        mask_key_next       = 32'd0;
                        mask_pos_next       = 2'd0;
                        if (in_byte_reg[6:0] == wsdf_pkg::LEN7_EXT16)
                        begin
                            ext_byte_count_next = wsdf_pkg::EXT16_BYTES;
                            phase_next          = wsdf_pkg::PH_EXT;
                        end
                        else if (in_byte_reg[6:0] == wsdf_pkg::LEN7_EXT64)
                        begin
                            ext_byte_count_next = wsdf_pkg::EXT64_BYTES;
                            phase_next          = wsdf_pkg::PH_EXT;
                        end
                        else
                        begin
                            remaining_len_next = LEN_BITS'(in_byte_reg & wsdf_pkg::LEN7_MASK);
                            phase_next         = wsdf_pkg::PH_KEY;
                        end
                    end
                end
                wsdf_pkg::PH_EXT:
                begin
                    // Length bits shifted out above LEN_BITS are dropped.
                    remaining_len_next  = {remaining_len_reg[LEN_BITS-9:0], in_byte_reg};
                    ext_byte_count_next = ext_dec;
                    if (ext_dec == 3'd0)
                    begin
                        phase_next = wsdf_pkg::PH_KEY;
                    end
                end
                wsdf_pkg::PH_KEY:
                begin
                    mask_key_next       = {mask_key_reg[23:0], in_byte_reg};
                    ext_byte_count_next = key_inc;
                    if (key_inc >= wsdf_pkg::KEY_BYTES)
                    begin
                        ext_byte_count_next = 3'd0;
                        mask_pos_next       = 2'd0;
                        if (remaining_len_reg == '0)
                        begin
                            phase_next = wsdf_pkg::PH_HDR0;
                            if (cur_opcode_reg == wsdf_pkg::OP_CLOSE)
                            begin
                                stopped_next    = 1'b1;
                                emit            = 1'b1;
                                out_end_next    = 1'b1;
                                out_status_next = wsdf_pkg::ST_CLOSED;
                            end
                            else if (is_data)
                            begin
                                emit         = 1'b1;
                                out_end_next = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = wsdf_pkg::PH_DATA;
                        end
                    end
                end
                wsdf_pkg::PH_DATA:
                begin
                    mask_pos_next      = mask_pos_reg + 2'd1;
                    remaining_len_next = len_dec;
                    if (len_dec == '0)
                    begin
                        phase_next = wsdf_pkg::PH_HDR0;
                        if (is_data)
                        begin
                            emit            = 1'b1;
                            out_byte_next   = in_byte_reg ^ key_byte;
                            out_bvalid_next = 1'b1;
                            out_end_next    = 1'b1;
                        end
                        else if (cur_opcode_reg == wsdf_pkg::OP_CLOSE)
                        begin
                            stopped_next    = 1'b1;
                            emit            = 1'b1;
                            out_end_next    = 1'b1;
                            out_status_next = wsdf_pkg::ST_CLOSED;
                        end
                    end
                    else if (is_data)
                    begin
                        emit            = 1'b1;
                        out_byte_next   = in_byte_reg ^ key_byte;
                        out_bvalid_next = 1'b1;
                    end
                end
                default:
                begin
                    cur_opcode_next = 4'(in_byte_reg & wsdf_pkg::OPCODE_MASK);
                    phase_next      = wsdf_pkg::PH_HDR1;
                end
            endcase
        end
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = emit;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            phase_reg          <= wsdf_pkg::PH_HDR0;
            cur_opcode_reg     <= 4'd0;
            remaining_len_reg  <= '0;
            ext_byte_count_reg <= 3'd0;
            mask_key_reg       <= 32'd0;
            mask_pos_reg       <= 2'd0;
            stopped_reg        <= 1'b0;
        end
        else
        begin
            in_valid_reg       <= in_valid_next;
            out_valid_reg      <= out_valid_next;
            phase_reg          <= phase_next;
            cur_opcode_reg     <= cur_opcode_next;
            remaining_len_reg  <= remaining_len_next;
            ext_byte_count_reg <= ext_byte_count_next;
            mask_key_reg       <= mask_key_next;
            mask_pos_reg       <= mask_pos_next;
            stopped_reg        <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            out_byte_reg   <= out_byte_next;
            out_opcode_reg <= out_opcode_next;
            out_bvalid_reg <= out_bvalid_next;
            out_end_reg    <= out_end_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_end_reg;
    assign m_tuser  = {out_status_reg, out_bvalid_reg, out_opcode_reg};

`ifndef NO_ASSERTIONS
    // A payload word is only ever delivered with an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[4]) |-> (m_tuser[6:5] == wsdf_pkg::ST_OK))
        else $error("payload word carries a non-ok status");

    // Closed and error reports always end the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[6:5] != wsdf_pkg::ST_OK)) |-> m_tlast)
        else $error("status report without frame end");

    // Stopping is always announced by a status word loaded at the same edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stopped_reg) |-> (m_tvalid && (m_tuser[6:5] != wsdf_pkg::ST_OK)))
        else $error("block stopped without reporting a status");

    // The payload phase is entered and kept only with bytes still to come.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wsdf_pkg::PH_DATA) |-> (remaining_len_reg != '0))
        else $error("payload phase with zero remaining length");
`endif

endmodule

// ===== dv/tb_websocket_frame_deframer.sv =====
// Self-checking testbench for websocket_frame_deframer: streams masked frames
// through the byte input and checks every unmasked output word against a
// behavioral model of the parser. Depends on wsdf_pkg and the design files.
module tb_websocket_frame_deframer;

    localparam int LEN_W       = wsdf_pkg::LEN_BITS_DEF;
    localparam int RX_WORDS    = 850;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 8;

    localparam logic [3:0] OP_PING = 4'h9;
    localparam logic [3:0] OP_PONG = 4'hA;

    typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] opc;
        logic       vld;
        logic       last;
        logic [1:0] st;
    } deframed_t;

    typedef struct {
        logic [7:0] data;
        bit         hold;
    } rx_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic       m_tlast;           // frame_end
    logic [6:0] m_tuser;           // [3:0] frame_opcode, [4] byte_valid, [6:5] status

    // Model of the parser state.
    logic [2:0]       ph = wsdf_pkg::PH_HDR0;
    logic [3:0]       op_q = 4'h0;
    logic [LEN_W-1:0] rem_len = '0;
    logic [2:0]       hdr_cnt = 3'd0;
    logic [31:0]      key_q = 32'h0;
    logic [1:0]       key_pos = 2'd0;
    bit               halted = 1'b0;

    deframed_t deframed_q[$];
    rx_word_t  rx_stream_q[$];
    rx_word_t  next_word;
    deframed_t got_word;
    deframed_t want_word;

    bit in_fire = 1'b0;
    bit out_fire = 1'b0;
    bit end_by_close = 1'b0;
    int in_gap = 0;
    int calm_words = 0;
    int rdy_left = 0;
    int idle_cycles = 0;
    int rx_queued = 0;
    int rx_taken = 0;
    int res_seen = 0;
    int mism = 0;
    int n_data_frames = 0;
    int n_empty_frames = 0;
    int n_silent_frames = 0;

    websocket_frame_deframer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    function automatic bit carries_data();
        return op_q == wsdf_pkg::OP_TEXT || op_q == wsdf_pkg::OP_BINARY;
    endfunction

    function automatic deframed_t frame_word(input logic [7:0] d, input logic vld,
                                             input logic last, input logic [1:0] st);
        frame_word = '{data: d, opc: op_q, vld: vld, last: last, st: st};
    endfunction

    task automatic end_of_frame(input bit had_bytes);
        ph = wsdf_pkg::PH_HDR0;
        if (op_q == wsdf_pkg::OP_CLOSE)
        begin
            halted = 1'b1;
            deframed_q.push_back(frame_word(8'h00, 1'b0, 1'b1, wsdf_pkg::ST_CLOSED));
        end
        else if (carries_data() && !had_bytes)
        begin
            deframed_q.push_back(frame_word(8'h00, 1'b0, 1'b1, wsdf_pkg::ST_OK));
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [6:0] len7;
        logic [7:0] v;
        if (!halted)
        begin
            case (ph)
                wsdf_pkg::PH_HDR1:
                begin
                    len7 = 7'(b & wsdf_pkg::LEN7_MASK);
                    if ((b & wsdf_pkg::MASK_BIT) == 8'h00)
                    begin
                        halted = 1'b1;
                        ph = wsdf_pkg::PH_HDR0;
                        deframed_q.push_back(frame_word(8'h00, 1'b0, 1'b1, wsdf_pkg::ST_ERROR));
                    end
                    else
                    begin
                        rem_len = '0;
                        hdr_cnt = 3'd0;
                        key_q = 32'h0;
                        key_pos = 2'd0;
                        if (len7 == wsdf_pkg::LEN7_EXT16)
                        begin
                            hdr_cnt = wsdf_pkg::EXT16_BYTES;
                            ph = wsdf_pkg::PH_EXT;
                        end
                        else if (len7 == wsdf_pkg::LEN7_EXT64)
                        begin
                            hdr_cnt = wsdf_pkg::EXT64_BYTES;
                            ph = wsdf_pkg::PH_EXT;
                        end
                        else
                        begin
                            rem_len = LEN_W'(len7);
                            ph = wsdf_pkg::PH_KEY;
                        end
                    end
                end
                wsdf_pkg::PH_EXT:
                begin
                    // Bits shifted past the top of the length register are lost.
                    rem_len = {rem_len[LEN_W-9:0], b};
                    hdr_cnt = hdr_cnt - 3'd1;
                    if (hdr_cnt == 3'd0)
                        ph = wsdf_pkg::PH_KEY;
                end
                wsdf_pkg::PH_KEY:
                begin
                    key_q = {key_q[23:0], b};
                    hdr_cnt = hdr_cnt + 3'd1;
                    if (hdr_cnt >= wsdf_pkg::KEY_BYTES)
                    begin
                        hdr_cnt = 3'd0;
                        key_pos = 2'd0;
                        if (rem_len == '0)
                            end_of_frame(1'b0);
                        else
                            ph = wsdf_pkg::PH_DATA;
                    end
                end
                wsdf_pkg::PH_DATA:
                begin
                    v = b ^ key_q[8 * (3 - key_pos) +: 8];
                    key_pos = key_pos + 2'd1;
                    rem_len = rem_len - 1'b1;
                    if (rem_len == '0)
                    begin
                        if (carries_data())
                        begin
                            ph = wsdf_pkg::PH_HDR0;
                            deframed_q.push_back(frame_word(v, 1'b1, 1'b1, wsdf_pkg::ST_OK));
                        end
                        else
                            end_of_frame(1'b1);
                    end
                    else if (carries_data())
                        deframed_q.push_back(frame_word(v, 1'b1, 1'b0, wsdf_pkg::ST_OK));
                end
                default:
                begin
                    op_q = 4'(b & wsdf_pkg::OPCODE_MASK);
                    ph = wsdf_pkg::PH_HDR1;
                end
            endcase
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input bit hold);
        rx_word_t w;
        w.data = b;
        w.hold = hold;
        rx_stream_q.push_back(w);
        rx_queued++;
    endtask

    // The top extended byte only matters for the 64-bit form, where its
    // upper bit falls outside the length register.
    task automatic queue_frame(input logic [3:0] opc, input logic [15:0] plen,
                               input len_form_t form, input logic [31:0] mkey,
                               input logic [7:0] ext_top, input bit hold);
        queue_byte({4'($urandom_range(0, 15)), opc}, hold);
        case (form)
            LEN_EXT16:
            begin
                queue_byte({1'b1, wsdf_pkg::LEN7_EXT16}, 1'b0);
                queue_byte(plen[15:8], 1'b0);
                queue_byte(plen[7:0], 1'b0);
            end
            LEN_EXT64:
            begin
                queue_byte({1'b1, wsdf_pkg::LEN7_EXT64}, 1'b0);
                queue_byte(ext_top, 1'b0);
                for (int i = 0; i < 5; i++)
                    queue_byte(8'h00, 1'b0);
                queue_byte(plen[15:8], 1'b0);
                queue_byte(plen[7:0], 1'b0);
            end
            default:
                queue_byte({1'b1, plen[6:0]}, 1'b0);
        endcase
        for (int i = 3; i >= 0; i--)
            queue_byte(mkey[8 * i +: 8], 1'b0);
        for (int i = 0; i < int'(plen); i++)
            queue_byte(8'($urandom()), 1'b0);
        if (opc == wsdf_pkg::OP_TEXT || opc == wsdf_pkg::OP_BINARY)
        begin
            n_data_frames++;
            if (plen == 16'd0)
                n_empty_frames++;
        end
        else if (opc != wsdf_pkg::OP_CLOSE)
            n_silent_frames++;
    endtask

    function automatic logic [3:0] silent_opcode();
        logic [3:0] o;
        do
            o = 4'($urandom_range(0, 15));
        while (o == wsdf_pkg::OP_TEXT || o == wsdf_pkg::OP_BINARY
               || o == wsdf_pkg::OP_CLOSE);
        return o;
    endfunction

    // Stimulus, reset and end of run.
    initial
    begin
        len_form_t   form;
        logic [15:0] plen;
        logic [3:0]  opc;
        int          r;
        bit          first_hold;

        first_hold = 1'b1;

        // Directed frames: extreme key values, an empty data frame, empty and
        // non-empty control frames, and both extended length forms, the 64-bit
        // one with its dropped top bit set.
        queue_frame(wsdf_pkg::OP_TEXT, 16'd1, LEN_SHORT, 32'hFFFF_FFFF, 8'h00, 1'b0);
        queue_frame(wsdf_pkg::OP_BINARY, 16'd0, LEN_SHORT, 32'h0000_0000, 8'h00, 1'b0);
        queue_frame(OP_PING, 16'd0, LEN_SHORT, $urandom(), 8'h00, 1'b0);
        queue_frame(OP_PONG, 16'd2, LEN_SHORT, $urandom(), 8'h00, 1'b0);
        queue_frame(wsdf_pkg::OP_BINARY, 16'd2, LEN_EXT64, 32'h8000_0001, 8'h80, 1'b0);
        queue_frame(wsdf_pkg::OP_TEXT, 16'd1, LEN_EXT16, $urandom(), 8'h00, 1'b0);

        while (rx_queued < RX_WORDS)
        begin
            r = $urandom_range(0, 99);
            opc = (r < 40) ? wsdf_pkg::OP_TEXT
                : (r < 75) ? wsdf_pkg::OP_BINARY : silent_opcode();
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                form = LEN_SHORT;
                plen = 16'($urandom_range(0, 8));
            end
            else if (r < 82)
            begin
                form = LEN_SHORT;
                plen = 16'($urandom_range(9, 40));
            end
            else if (r < 88)
            begin
                form = LEN_SHORT;
                plen = 16'($urandom_range(0, 125));
            end
            else if (r < 95)
            begin
                form = LEN_EXT16;
                plen = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(126, 300))
                                                   : 16'($urandom_range(0, 12));
            end
            else
            begin
                form = LEN_EXT64;
                plen = 16'($urandom_range(0, 12));
            end
            queue_frame(opc, plen, form, $urandom(), {1'($urandom_range(0, 1)), 7'h00},
                        first_hold || ($urandom_range(0, 99) < 4));
            first_hold = 1'b0;
        end

        // The stream ends with either a close frame or an unmasked header;
        // both stop the parser, so the trailing bytes must yield nothing.
        end_by_close = 1'($urandom_range(0, 1));
        if (end_by_close)
            queue_frame(wsdf_pkg::OP_CLOSE, 16'($urandom_range(0, 5)), LEN_SHORT,
                        $urandom(), 8'h00, 1'b0);
        else
        begin
            queue_byte(8'($urandom()), 1'b0);
            queue_byte({1'b0, 7'($urandom_range(0, 127))}, 1'b0);
        end
        for (int i = 0; i < 5; i++)
            queue_byte(8'($urandom()), 1'b0);

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        while (!(rx_taken == rx_queued && deframed_q.size() == 0))
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Streamed %0d bytes: %0d text/binary frames (%0d empty), %0d discarded frames.",
                 rx_taken, n_data_frames, n_empty_frames, n_silent_frames);
        $display("Checked %0d result words; stream ended by %s, %0d mismatches.",
                 res_seen, end_by_close ? "a close frame" : "an unmasked header", mism);
        if (mism == 0 && deframed_q.size() == 0)
            $display("tb_websocket_frame_deframer: PASS");
        else
            $display("tb_websocket_frame_deframer: FAIL");
        $finish;
    end

    // Byte source. A word marked hold waits until every pending result is out.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                s_tvalid <= 1'b0;
            end
            else if (rx_stream_q.size() != 0
                     && !(rx_stream_q[0].hold && deframed_q.size() != 0))
            begin
                next_word = rx_stream_q.pop_front();
                s_tdata  <= next_word.data;
                s_tvalid <= 1'b1;
                if (calm_words > 0)
                begin
                    calm_words--;
                    in_gap = 0;
                end
                else
                begin
                    in_gap = pick_idle();
                    if ($urandom_range(0, 99) == 0)
                        calm_words = $urandom_range(30, 100);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result sink with random backpressure.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rdy_left > 0)
                rdy_left--;
            else if ($urandom_range(0, 99) < 65)
            begin
                m_tready <= 1'b1;
                rdy_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(0, 12);
            end
            else
            begin
                m_tready <= 1'b0;
                rdy_left = pick_idle();
            end
        end
    end

    // Handshake monitor: model update on input words, check on output words.
    always @(posedge clk)
    begin
        in_fire  = rst_n && s_tvalid && s_tready;
        out_fire = rst_n && m_tvalid && m_tready;
        if (in_fire)
        begin
            deframe_byte(s_tdata);
            rx_taken++;
        end
        if (out_fire)
        begin
            got_word = '{data: m_tdata, opc: m_tuser[3:0], vld: m_tuser[4],
                         last: m_tlast, st: m_tuser[6:5]};
            res_seen++;
            if (deframed_q.size() == 0)
            begin
                mism++;
                if (mism <= 10)
                    $display("unexpected result word %0d: byte %02h op %h valid %b last %b st %0d",
                             res_seen, got_word.data, got_word.opc, got_word.vld,
                             got_word.last, got_word.st);
            end
            else
            begin
                want_word = deframed_q.pop_front();
                if (got_word.data !== want_word.data || got_word.opc !== want_word.opc
                    || got_word.vld !== want_word.vld || got_word.last !== want_word.last
                    || got_word.st !== want_word.st)
                begin
                    mism++;
                    if (mism <= 10)
                    begin
                        $display("result word %0d mismatch: expected byte %02h op %h valid %b last %b st %0d",
                                 res_seen, want_word.data, want_word.opc, want_word.vld,
                                 want_word.last, want_word.st);
                        $display("    got byte %02h op %h valid %b last %b st %0d",
                                 got_word.data, got_word.opc, got_word.vld,
                                 got_word.last, got_word.st);
                    end
                end
            end
        end
    end

    // Ends a hung run when no word moves on either side for too long.
    always @(negedge clk)
    begin
        if (rst_n && !in_fire && !out_fire)
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("No word accepted for %0d cycles; %0d results still pending.",
                     IDLE_LIMIT, deframed_q.size());
            $display("tb_websocket_frame_deframer: FAIL");
            $finish;
        end
    end

endmodule
